/* hdl/morph3_pkg.sv */
// morph3_pkg: shared types and constants of the 3x3 morphology stream block
// no dependencies; used by the interfaces and all modules
`default_nettype none

package morph3_pkg;

    localparam int PIXEL_W   = 8;
    localparam int WORD_W    = 2 * PIXEL_W;
    localparam int SIZE_W    = 11;
    localparam int SIZE_MIN  = 3;
    localparam int REG_IDX_W = 3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef logic [PIXEL_W-1:0] t_pixel;
    typedef logic [SIZE_W-1:0]  t_size;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_opcode;

    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    localparam t_reg_idx REG_MODE         = 3'd0;
    localparam t_reg_idx REG_LOW_LEVEL    = 3'd1;
    localparam t_reg_idx REG_HIGH_LEVEL   = 3'd2;
    localparam t_reg_idx REG_LINE_WIDTH   = 3'd3;
    localparam t_reg_idx REG_FRAME_HEIGHT = 3'd4;

    localparam logic   MODE_RESET         = MODE_ERODE;
    localparam t_pixel LOW_LEVEL_RESET    = 8'd0;
    localparam t_pixel HIGH_LEVEL_RESET   = 8'd255;
    localparam t_size  LINE_WIDTH_RESET   = 11'd720;
    localparam t_size  FRAME_HEIGHT_RESET = 11'd576;

    typedef struct packed {
        t_size line_width;
        t_size frame_height;
    } t_cfg_sizes;

    typedef struct packed {
        logic   mode;
        t_pixel low_level;
        t_pixel high_level;
    } t_cfg_levels;

    typedef struct packed {
        logic   is_flush;
        logic   emit;
        logic   use_mem;
        logic   interior;
        logic   line_end;
        logic   frame_end;
        t_pixel pixel;
    } t_cmd;

endpackage

`default_nettype wire

/* hdl/morph3_if.sv */
// morph3 channel interfaces: pixel input, pixel output, register write
// depends on morph3_pkg
`default_nettype none

interface morph3_in_if;
    logic                valid;
    logic                ready;
    morph3_pkg::t_opcode opcode;
    morph3_pkg::t_pixel  pixel_in;
    modport source (output valid, output opcode, output pixel_in, input ready);
    modport sink (input valid, input opcode, input pixel_in, output ready);
endinterface

interface morph3_out_if;
    logic               valid;
    logic               ready;
    morph3_pkg::t_pixel pixel_out;
    logic               line_end;
    logic               frame_end;
    modport source (output valid, output pixel_out, output line_end, output frame_end,
                    input ready);
    modport sink (input valid, input pixel_out, input line_end, input frame_end,
                  output ready);
endinterface

interface morph3_cfg_if;
    logic                 valid;
    logic                 ready;
    morph3_pkg::t_reg_idx index;
    morph3_pkg::t_size    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/morphology_3x3_stream.sv */
// morphology_3x3_stream: top level, register file, front, command queue and back
// depends on morph3_pkg, morph3_if, morph3_front, morph3_fifo, morph3_back
//
//   channel  | port   | direction | carries
//   ---------+--------+-----------+-------------------------------------
//   pixel in | i_pix  | sink      | opcode, pixel_in
//   pixel out| o_pix  | source    | pixel_out, line_end, frame_end
//   register | i_cfg  | sink      | index, data (always ready)
//
// one transaction per clock sustained in both directions while the output does not
// stall; a pixel result passes the queue, the line store read and the output register
// the line store is one synchronous memory, read and written at most once per cycle
// reset clears positions, owed count, window and registers; line store contents
// stay undefined, there is no clearing pass
// an output stall holds the execute stage, then fills the 4-entry queue before
// i_pix.ready drops
`default_nettype none

module morphology_3x3_stream #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    morph3_in_if.sink     i_pix,
    morph3_out_if.source  o_pix,
    morph3_cfg_if.sink    i_cfg
);
    import morph3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic          r_mode;
    t_pixel        r_low, r_high;
    t_size         r_line_width, r_frame_height;

    t_cfg_sizes    sizes;
    t_cfg_levels   levels;

    logic          push_valid, push_ready, pop_valid, pop_ready;
    t_cmd          push_cmd, pop_cmd;
    logic [AW-1:0] push_addr, pop_addr;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_RESET;
            r_low          <= LOW_LEVEL_RESET;
            r_high         <= HIGH_LEVEL_RESET;
            r_line_width   <= LINE_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MODE: begin
                    r_mode <= i_cfg.data[0];
                end
                REG_LOW_LEVEL: begin
                    r_low <= i_cfg.data[PIXEL_W-1:0];
                end
                REG_HIGH_LEVEL: begin
                    r_high <= i_cfg.data[PIXEL_W-1:0];
                end
                REG_LINE_WIDTH: begin
                    r_line_width <= i_cfg.data;
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    assign sizes.line_width   = r_line_width;
    assign sizes.frame_height = r_frame_height;
    assign levels.mode        = r_mode;
    assign levels.low_level   = r_low;
    assign levels.high_level  = r_high;

    morph3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (i_pix),
        .i_sizes      (sizes),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_cmd        (push_cmd),
        .o_addr       (push_addr)
    );

    morph3_fifo #(
        .AW (AW)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_cmd        (push_cmd),
        .i_addr       (push_addr),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_cmd        (pop_cmd),
        .o_addr       (pop_addr)
    );

    morph3_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_cmd       (pop_cmd),
        .i_addr      (pop_addr),
        .i_levels    (levels),
        .o_pix       (o_pix)
    );

endmodule

`default_nettype wire

/* hdl/morph3_front.sv */
// morph3_front: accepts input transactions, tracks raster positions and owed pixels,
// and issues one command per pixel or active flush; depends on morph3_pkg, morph3_if
`default_nettype none

module morph3_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    morph3_in_if.sink                     i_pix,
    input  morph3_pkg::t_cfg_sizes        i_sizes,
    output logic                          o_push_valid,
    input  logic                          i_push_ready,
    output morph3_pkg::t_cmd              o_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_addr
);
    import morph3_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WB  = $clog2(MAX_WIDTH + 1);
    localparam int HB  = $clog2(MAX_HEIGHT + 1);
    localparam int XW  = ((WB > SIZE_W) ? WB : SIZE_W) + 1;
    localparam int YW  = ((HB > SIZE_W) ? HB : SIZE_W) + 1;
    localparam int PW  = $clog2(MAX_WIDTH + 2);

    logic [CW-1:0] r_in_col, n_in_col;
    logic [RW-1:0] r_in_row, n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [RW-1:0] r_out_row, n_out_row;
    logic [PW-1:0] r_pend, n_pend;

    logic [XW-1:0] eff_w;
    logic [YW-1:0] eff_h;
    logic [PW-1:0] lag;
    logic          accept, is_flush, at_start, restart, flush_act, emit;
    logic [CW-1:0] oc;
    logic [RW-1:0] orw;
    logic [PW-1:0] pend0;
    logic          line_end, last_row, interior, in_line_end, in_last_row;

    always_comb begin
        if (XW'(i_sizes.line_width) < XW'(SIZE_MIN)) begin
            eff_w = XW'(SIZE_MIN);
        end else if (XW'(i_sizes.line_width) > XW'(MAX_WIDTH)) begin
            eff_w = XW'(MAX_WIDTH);
        end else begin
            eff_w = XW'(i_sizes.line_width);
        end
        if (YW'(i_sizes.frame_height) < YW'(SIZE_MIN)) begin
            eff_h = YW'(SIZE_MIN);
        end else if (YW'(i_sizes.frame_height) > YW'(MAX_HEIGHT)) begin
            eff_h = YW'(MAX_HEIGHT);
        end else begin
            eff_h = YW'(i_sizes.frame_height);
        end
    end

    assign lag         = PW'(eff_w) + PW'(1);
    assign i_pix.ready = i_push_ready;
    assign accept      = i_pix.valid && i_push_ready;
    assign is_flush    = (i_pix.opcode == OP_FLUSH);
    assign at_start    = (r_in_col == '0) && (r_in_row == '0);
    assign restart     = !is_flush && at_start && (r_pend < lag);
    assign oc          = restart ? '0 : r_out_col;
    assign orw         = restart ? '0 : r_out_row;
    assign pend0       = restart ? '0 : r_pend;
    assign flush_act   = is_flush && at_start && (r_pend != '0);
    assign emit        = is_flush ? flush_act : (pend0 >= lag);

    assign line_end    = (XW'(oc) + XW'(1)) >= eff_w;
    assign last_row    = (YW'(orw) + YW'(1)) >= eff_h;
    assign interior    = (orw != '0) && ((YW'(orw) + YW'(2)) <= eff_h) &&
                         (oc != '0) && ((XW'(oc) + XW'(2)) <= eff_w);
    assign in_line_end = (XW'(r_in_col) + XW'(1)) >= eff_w;
    assign in_last_row = (YW'(r_in_row) + YW'(1)) >= eff_h;

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = oc;
        n_out_row = orw;
        n_pend    = r_pend;
        if (emit) begin
            if (line_end) begin
                n_out_col = '0;
                n_out_row = last_row ? '0 : orw + RW'(1);
            end else begin
                n_out_col = oc + CW'(1);
            end
        end
        if (is_flush) begin
            if (flush_act) begin
                n_pend = r_pend - PW'(1);
            end
        end else begin
            n_pend = emit ? lag : pend0 + PW'(1);
            if (in_line_end) begin
                n_in_col = '0;
                n_in_row = in_last_row ? '0 : r_in_row + RW'(1);
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pend    <= '0;
        end else if (accept) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_pend    <= n_pend;
        end
    end

    assign o_push_valid    = accept && (!is_flush || flush_act);
    assign o_cmd.is_flush  = is_flush;
    assign o_cmd.emit      = emit;
    assign o_cmd.use_mem   = last_row;
    assign o_cmd.interior  = interior;
    assign o_cmd.line_end  = line_end;
    assign o_cmd.frame_end = line_end && last_row;
    assign o_cmd.pixel     = i_pix.pixel_in;
    assign o_addr          = is_flush ? r_out_col : r_in_col;

endmodule

`default_nettype wire

/* hdl/morph3_fifo.sv */
// morph3_fifo: short command queue between the front and the back
// depends on morph3_pkg
`default_nettype none

module morph3_fifo #(
    parameter int AW = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  morph3_pkg::t_cmd  i_cmd,
    input  logic [AW-1:0]     i_addr,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output morph3_pkg::t_cmd  o_cmd,
    output logic [AW-1:0]     o_addr
);
    import morph3_pkg::*;

    t_cmd                r_cmd  [FIFO_DEPTH];
    logic [AW-1:0]       r_addr [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_PTR_W:0]   r_count;
    logic                push, pop;

    assign o_push_ready = (r_count != (FIFO_PTR_W + 1)'(FIFO_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_cmd        = r_cmd[r_rd_ptr];
    assign o_addr       = r_addr[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_cmd[r_wr_ptr]  <= i_cmd;
            r_addr[r_wr_ptr] <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (FIFO_PTR_W + 1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (FIFO_PTR_W + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/morph3_back.sv */
// morph3_back: line store memory, 3x3 window, neighbour test and output register
// depends on morph3_pkg, morph3_if
`default_nettype none

module morph3_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_pop_valid,
    output logic                          o_pop_ready,
    input  morph3_pkg::t_cmd              i_cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_addr,
    input  morph3_pkg::t_cfg_levels       i_levels,
    morph3_out_if.source                  o_pix
);
    import morph3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    // word layout: upper line in the high byte, middle line in the low byte
    logic [WORD_W-1:0] r_mem [MAX_WIDTH];
    logic [WORD_W-1:0] r_rd, r_byp_data, rd, wr_data;
    logic              r_byp;

    logic              r_ex_valid;
    t_cmd              r_ex_cmd;
    logic [AW-1:0]     r_ex_addr;

    t_pixel            r_win [3][3];
    t_pixel            n_win [3][3];

    logic              r_out_valid, r_out_le, r_out_fe;
    t_pixel            r_out_pix;

    logic              ex_done, pop_fire, wr_en, hit;
    t_pixel            target, result;

    assign ex_done     = r_ex_valid && (!r_ex_cmd.emit || !r_out_valid || o_pix.ready);
    assign o_pop_ready = !r_ex_valid || ex_done;
    assign pop_fire    = i_pop_valid && o_pop_ready;
    assign wr_en       = ex_done && !r_ex_cmd.is_flush;
    assign rd          = r_byp ? r_byp_data : r_rd;
    assign wr_data     = {rd[PIXEL_W-1:0], r_ex_cmd.pixel};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_ex_addr] <= wr_data;
        end
        if (pop_fire) begin
            r_rd       <= r_mem[i_addr];
            r_byp_data <= wr_data;
            r_ex_cmd   <= i_cmd;
            r_ex_addr  <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else begin
            if (pop_fire) begin
                r_ex_valid <= 1'b1;
                r_byp      <= wr_en && (r_ex_addr == i_addr);
            end else if (ex_done) begin
                r_ex_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_win[r][c] = r_win[r][c];
            end
        end
        if (wr_en) begin
            for (int r = 0; r < 3; r++) begin
                n_win[r][0] = r_win[r][1];
                n_win[r][1] = r_win[r][2];
            end
            n_win[0][2] = rd[WORD_W-1:PIXEL_W];
            n_win[1][2] = rd[PIXEL_W-1:0];
            n_win[2][2] = r_ex_cmd.pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= n_win[r][c];
                end
            end
        end
    end

    assign target = (i_levels.mode == MODE_DILATE) ? i_levels.high_level : i_levels.low_level;

    always_comb begin
        hit = 1'b0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (!(r == 1 && c == 1) && (n_win[r][c] == target)) begin
                    hit = 1'b1;
                end
            end
        end
        if (r_ex_cmd.is_flush) begin
            result = r_ex_cmd.use_mem ? rd[PIXEL_W-1:0] : r_win[1][2];
        end else begin
            result = (r_ex_cmd.interior && hit) ? target : n_win[1][1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ex_done && r_ex_cmd.emit) begin
            r_out_pix <= result;
            r_out_le  <= r_ex_cmd.line_end;
            r_out_fe  <= r_ex_cmd.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ex_done && r_ex_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.pixel_out = r_out_pix;
    assign o_pix.line_end  = r_out_le;
    assign o_pix.frame_end = r_out_fe;

endmodule

`default_nettype wire

/* tb/sv/morph3_checker_pkg.sv */
// morph3_checker_pkg: cycle-free predictor and result checker for the 3x3 morphology stream
// depends on morph3_pkg; used by tb_morphology_3x3_stream
`default_nettype none

package morph3_checker_pkg;

    import morph3_pkg::*;

    localparam int LINE_DEPTH = 1024;
    localparam int MAX_LINES  = 1024;
    localparam int REPORT_MAX = 10;

    typedef struct {
        t_pixel pixel;
        logic   line_end;
        logic   frame_end;
    } t_out_pixel;

    class morph3_checker;
        logic        mode;
        t_pixel      low_lvl;
        t_pixel      high_lvl;
        t_size       width_reg;
        t_size       height_reg;
        t_pixel      upper_line[LINE_DEPTH];
        t_pixel      middle_line[LINE_DEPTH];
        t_pixel      win[3][3];
        int unsigned in_col;
        int unsigned in_row;
        int unsigned out_col;
        int unsigned out_row;
        int unsigned owed_cnt;
        t_out_pixel  owed_pixels[$];
        int          fail_count;
        int unsigned result_no;

        function new();
            mode       = MODE_RESET;
            low_lvl    = LOW_LEVEL_RESET;
            high_lvl   = HIGH_LEVEL_RESET;
            width_reg  = LINE_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            foreach (upper_line[i]) begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            foreach (win[r, c]) win[r][c] = '0;
            in_col     = 0;
            in_row     = 0;
            out_col    = 0;
            out_row    = 0;
            owed_cnt   = 0;
            fail_count = 0;
            result_no  = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg < SIZE_MIN) return SIZE_MIN;
            if (width_reg > LINE_DEPTH) return LINE_DEPTH;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg < SIZE_MIN) return SIZE_MIN;
            if (height_reg > MAX_LINES) return MAX_LINES;
            return height_reg;
        endfunction

        function void write_reg(t_reg_idx idx, t_size data);
            case (idx)
                REG_MODE:         mode = data[0];
                REG_LOW_LEVEL:    low_lvl = data[PIXEL_W-1:0];
                REG_HIGH_LEVEL:   high_lvl = data[PIXEL_W-1:0];
                REG_LINE_WIDTH:   width_reg = data;
                REG_FRAME_HEIGHT: height_reg = data;
                default: ;
            endcase
        endfunction

        function void step_pos(inout int unsigned col, inout int unsigned row,
                               input int unsigned w, input int unsigned h);
            if (col + 1 >= w) begin
                col = 0;
                row = (row + 1 >= h) ? 0 : row + 1;
            end else begin
                col = col + 1;
            end
        endfunction

        function void push_result(t_pixel val, int unsigned w, int unsigned h);
            t_out_pixel px;
            px.pixel     = val;
            px.line_end  = (out_col + 1 >= w);
            px.frame_end = (out_col + 1 >= w) && (out_row + 1 >= h);
            owed_pixels.push_back(px);
            step_pos(out_col, out_row, w, h);
        endfunction

        // border pixels pass, interior pixels snap to the target level when a neighbour holds it
        function t_pixel center_value(int unsigned w, int unsigned h);
            t_pixel tgt;
            int     r;
            int     c;
            tgt = (mode == MODE_DILATE) ? high_lvl : low_lvl;
            if (out_row < 1 || out_row + 2 > h || out_col < 1 || out_col + 2 > w)
                return win[1][1];
            for (r = 0; r < 3; r++)
                for (c = 0; c < 3; c++)
                    if (!(r == 1 && c == 1) && win[r][c] == tgt) return tgt;
            return win[1][1];
        endfunction

        function void take_input(t_opcode op, t_pixel pix);
            int unsigned w;
            int unsigned h;
            int unsigned lag;
            int unsigned idx;
            bit          at_start;
            t_pixel      up;
            t_pixel      mid;
            w        = eff_width();
            h        = eff_height();
            lag      = w + 1;
            at_start = (in_col == 0) && (in_row == 0);
            if (op == OP_FLUSH) begin
                if (!at_start || owed_cnt == 0) return;
                idx = out_col % LINE_DEPTH;
                push_result((out_row + 1 >= h) ? middle_line[idx] : win[1][2], w, h);
                owed_cnt--;
                return;
            end
            // new frame before the old one is fully drained
            if (at_start && owed_cnt < lag) begin
                owed_cnt = 0;
                out_col  = 0;
                out_row  = 0;
            end
            idx = in_col % LINE_DEPTH;
            up  = upper_line[idx];
            mid = middle_line[idx];
            for (int r = 0; r < 3; r++) begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2]        = up;
            win[1][2]        = mid;
            win[2][2]        = pix;
            upper_line[idx]  = mid;
            middle_line[idx] = pix;
            step_pos(in_col, in_row, w, h);
            if (owed_cnt >= lag) begin
                owed_cnt = lag;
                push_result(center_value(w, h), w, h);
            end else begin
                owed_cnt++;
            end
        endfunction

        function void note_fail(string msg);
            fail_count++;
            if (fail_count <= REPORT_MAX) $display("ERROR: %s", msg);
        endfunction

        function void check_result(t_pixel pix, logic line_end, logic frame_end);
            t_out_pixel exp_px;
            result_no++;
            if (owed_pixels.size() == 0) begin
                note_fail($sformatf("output %0d: unexpected pixel %0d line_end %b frame_end %b",
                                    result_no, pix, line_end, frame_end));
                return;
            end
            exp_px = owed_pixels.pop_front();
            if (exp_px.pixel !== pix)
                note_fail($sformatf("output %0d: pixel expected %0d got %0d",
                                    result_no, exp_px.pixel, pix));
            if (exp_px.line_end !== line_end)
                note_fail($sformatf("output %0d: line_end expected %b got %b",
                                    result_no, exp_px.line_end, line_end));
            if (exp_px.frame_end !== frame_end)
                note_fail($sformatf("output %0d: frame_end expected %b got %b",
                                    result_no, exp_px.frame_end, frame_end));
        endfunction
    endclass

endpackage

`default_nettype wire

/* tb/sv/tb_morphology_3x3_stream.sv */
// tb_morphology_3x3_stream: drives pixel, flush and register transactions into the
// 3x3 morphology stream and checks every output pixel against morph3_checker_pkg
// depends on morph3_pkg, morph3_if, morph3_checker_pkg and morphology_3x3_stream
`default_nettype none

module tb_morphology_3x3_stream;

    import morph3_pkg::*;
    import morph3_checker_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_TARGET = 340;
    localparam int WIDE_PIXELS   = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int RUN_LIMIT     = 2_000_000;

    typedef struct {
        t_reg_idx idx;
        t_size    data;
    } t_reg_write;

    logic i_clk;
    logic i_rst_n;

    morph3_in_if  pix_in_if ();
    morph3_out_if pix_out_if ();
    morph3_cfg_if cfg_wr_if ();

    morph3_checker model_chk;
    t_reg_write    reg_writes[$];
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            hold_off_left  = 0;
    int            random_items   = 0;

    morphology_3x3_stream dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in_if),
        .o_pix   (pix_out_if),
        .i_cfg   (cfg_wr_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #RUN_LIMIT;
        $display("Some tests failed");
        $finish;
    end

    // output side: random stalls plus one long hold-off
    initial begin
        pix_out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_left > 0) begin
                pix_out_if.ready <= 1'b0;
                hold_off_left--;
            end else begin
                pix_out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_wr_if.valid && cfg_wr_if.ready)
                model_chk.write_reg(cfg_wr_if.index, cfg_wr_if.data);
            if (pix_in_if.valid && pix_in_if.ready)
                model_chk.take_input(pix_in_if.opcode, pix_in_if.pixel_in);
            if (pix_out_if.valid && pix_out_if.ready)
                model_chk.check_result(pix_out_if.pixel_out, pix_out_if.line_end,
                                       pix_out_if.frame_end);
        end
    end

    function automatic t_pixel pick_pixel();
        case ($urandom_range(3))
            0, 1:    return model_chk.low_lvl;
            2:       return model_chk.high_lvl;
            default: return t_pixel'($urandom);
        endcase
    endfunction

    function automatic t_pixel pick_level();
        case ($urandom_range(3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return t_pixel'($urandom);
        endcase
    endfunction

    function automatic void queue_reg(t_reg_idx idx, t_size data);
        t_reg_write wr;
        wr.idx  = idx;
        wr.data = data;
        reg_writes.push_back(wr);
    endfunction

    task automatic set_profile(int profile);
        case (profile)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
        endcase
    endtask

    task automatic send_item(t_opcode op, t_pixel pix);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in_if.valid    <= 1'b1;
        pix_in_if.opcode   <= op;
        pix_in_if.pixel_in <= pix;
        do @(posedge i_clk); while (!pix_in_if.ready);
    endtask

    task automatic send_pixels(int n);
        repeat (n) send_item(OP_PIXEL, pick_pixel());
    endtask

    task automatic send_flushes(int n);
        repeat (n) send_item(OP_FLUSH, t_pixel'($urandom));
    endtask

    // stop sending, wait for all owed pixels, then let the pipeline go quiet
    task automatic settle();
        pix_in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (model_chk.owed_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_regs();
        t_reg_write wr;
        while (reg_writes.size() > 0) begin
            wr = reg_writes.pop_front();
            cfg_wr_if.valid <= 1'b1;
            cfg_wr_if.index <= wr.idx;
            cfg_wr_if.data  <= wr.data;
            do @(posedge i_clk); while (!cfg_wr_if.ready);
        end
        cfg_wr_if.valid <= 1'b0;
    endtask

    initial begin
        int unsigned w;
        int unsigned h;
        int unsigned n_flush;
        int unsigned frames;
        int          phase_no;

        model_chk = new();
        i_rst_n            <= 1'b0;
        pix_in_if.valid    <= 1'b0;
        pix_in_if.opcode   <= OP_PIXEL;
        pix_in_if.pixel_in <= '0;
        cfg_wr_if.valid    <= 1'b0;
        cfg_wr_if.index    <= REG_MODE;
        cfg_wr_if.data     <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: smallest frame via saturating sizes, ignored flushes, mid-frame mode change
        set_profile(0);
        queue_reg(REG_MODE, t_size'(MODE_ERODE));
        queue_reg(REG_LOW_LEVEL, 11'd0);
        queue_reg(REG_HIGH_LEVEL, 11'd255);
        queue_reg(REG_LINE_WIDTH, 11'd1);
        queue_reg(REG_FRAME_HEIGHT, 11'd2);
        apply_regs();
        send_item(OP_FLUSH, 8'hff);
        send_item(OP_PIXEL, 8'd0);
        send_item(OP_PIXEL, 8'd255);
        send_item(OP_PIXEL, 8'd0);
        send_item(OP_FLUSH, 8'h00);
        send_item(OP_PIXEL, 8'd255);
        send_item(OP_PIXEL, 8'd128);
        send_item(OP_PIXEL, 8'd255);
        send_item(OP_PIXEL, 8'd0);
        send_item(OP_PIXEL, 8'd0);
        send_item(OP_PIXEL, 8'd255);
        send_flushes(5);
        send_item(OP_PIXEL, 8'd200);
        send_item(OP_PIXEL, 8'd1);
        send_item(OP_PIXEL, 8'd7);
        send_item(OP_PIXEL, 8'd1);
        send_item(OP_PIXEL, 8'd50);
        settle();
        queue_reg(REG_MODE, t_size'(MODE_DILATE));
        queue_reg(REG_HIGH_LEVEL, 11'd1);
        apply_regs();
        send_item(OP_PIXEL, 8'd1);
        send_item(OP_PIXEL, 8'd200);
        send_item(OP_PIXEL, 8'd1);
        send_item(OP_PIXEL, 8'd255);
        // partial drain, cut short by the next frame
        send_flushes(2);

        // tallest frame, cut down to the minimum height mid-frame; long output hold-off
        settle();
        set_profile(3);
        queue_reg(REG_MODE, t_size'(MODE_DILATE));
        queue_reg(REG_HIGH_LEVEL, 11'd255);
        queue_reg(REG_LINE_WIDTH, 11'd9);
        queue_reg(REG_FRAME_HEIGHT, 11'd1024);
        apply_regs();
        hold_off_left = HOLD_CYCLES;
        send_pixels(60);
        settle();
        queue_reg(REG_FRAME_HEIGHT, 11'd3);
        apply_regs();
        send_pixels(30);
        send_flushes(10);

        phase_no = 0;
        while (random_items < RANDOM_TARGET) begin
            settle();
            set_profile(phase_no % 4);
            queue_reg(REG_MODE, t_size'($urandom_range(1)));
            queue_reg(REG_LOW_LEVEL, t_size'(pick_level()));
            queue_reg(REG_HIGH_LEVEL, t_size'(pick_level()));
            queue_reg(REG_LINE_WIDTH, ($urandom_range(9) == 0) ?
                      t_size'($urandom_range(2)) : t_size'($urandom_range(3, 9)));
            queue_reg(REG_FRAME_HEIGHT, ($urandom_range(9) == 0) ?
                      t_size'($urandom_range(2)) : t_size'($urandom_range(3, 7)));
            apply_regs();
            w      = model_chk.eff_width();
            h      = model_chk.eff_height();
            frames = $urandom_range(1, 3);
            repeat (frames) begin
                for (int k = 0; k < w * h; k++) begin
                    if ($urandom_range(29) == 0) send_item(OP_FLUSH, t_pixel'($urandom));
                    if (k == (w * h) / 2 && $urandom_range(5) == 0) begin
                        settle();
                        queue_reg(REG_MODE, t_size'($urandom_range(1)));
                        queue_reg($urandom_range(1) ? REG_LOW_LEVEL : REG_HIGH_LEVEL,
                                  t_size'(pick_level()));
                        apply_regs();
                    end
                    send_item(OP_PIXEL, pick_pixel());
                    random_items++;
                end
            end
            // full drain, partial drain or none before the next setting
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    send_flushes(w + 1 + $urandom_range(1));
                    n_flush = w + 1;
                end
                6, 7, 8: begin
                    n_flush = $urandom_range(w);
                    send_flushes(n_flush);
                end
                default: n_flush = 0;
            endcase
            random_items += n_flush;
            phase_no++;
        end

        // widest line, saturated from above; no output is due within the first line
        settle();
        set_profile(0);
        queue_reg(REG_MODE, t_size'(MODE_ERODE));
        queue_reg(REG_LOW_LEVEL, 11'd0);
        queue_reg(REG_HIGH_LEVEL, 11'd255);
        queue_reg(REG_LINE_WIDTH, 11'd2047);
        queue_reg(REG_FRAME_HEIGHT, 11'd3);
        apply_regs();
        send_pixels(WIDE_PIXELS);

        settle();
        if (model_chk.fail_count == 0 && model_chk.owed_pixels.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
hdl/morph3_pkg.sv
hdl/morph3_if.sv
hdl/morph3_front.sv
hdl/morph3_fifo.sv
hdl/morph3_back.sv
hdl/morphology_3x3_stream.sv
tb/sv/morph3_checker_pkg.sv
tb/sv/tb_morphology_3x3_stream.sv
